// ===== rtl/core/fqkr_pkg.sv =====
// fqkr_pkg: types, codes and sizes shared by the ticket queue and its cells.
// No dependencies.
package fqkr_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Ids are held and compared in their low ID_BITS bits
    localparam logic [15:0] ID_MASK = 16'((33'd1 << ID_BITS) - 33'd1);

    // Operation codes
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_LOOKUP = 2'd3
    } t_mode;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_MISS  = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] ticket_id;
        logic [7:0]  ticket_priority;
        logic [31:0] ticket_payload;
    } t_in;

    // Output beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic [31:0] out_payload;
        logic [4:0]  occupancy;
    } t_out;

    // One stored record
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] payload;
    } t_rec;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic load;   // take the new record
        logic shift;  // take the neighbour's record and valid
    } t_cell_ctl;

endpackage

// ===== rtl/core/fifo_queue_with_key_removal.sv =====
// fifo_queue_with_key_removal: top level of the ticket queue with removal by id.
// Depends on fqkr_pkg and fqkr_cell.
//
// Ordered queue of up to 16 ticket records held in a row of cells, head in
// cell 0. Each input beat (push, pop, remove by id, look up by id) gives one
// output beat with status, the record concerned and the occupancy afterwards.
// The beat is registered on acceptance; in the following cycle each cell
// compares its id with the key in parallel and the first match is picked;
// a push fills the first free cell, a pop or removal closes the cells up by
// one place from the head or the match, and the result enters the output
// register. A new beat is taken only when the queue is idle and the output
// register is empty or drained in that cycle, so beats never overlap. No
// clearing pass after reset: only the state, count and valid flags are reset.
module fifo_queue_with_key_removal (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fqkr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fqkr_pkg::t_out o_out_data
);

    localparam int DEPTH = fqkr_pkg::QUEUE_DEPTH;
    localparam int CNT_W = fqkr_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    fqkr_pkg::t_in               r_op;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid;
    fqkr_pkg::t_out              r_out, n_out;

    fqkr_pkg::t_rec              w_rec [DEPTH];
    fqkr_pkg::t_cell_ctl         w_ctl [DEPTH];
    logic [DEPTH-1:0]            w_valid;
    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0]            w_first;
    logic [DEPTH-1:0]            w_hit;
    logic [DEPTH-1:0]            w_shift;
    logic [DEPTH-1:0]            w_load;
    logic [15:0]                 w_key;
    fqkr_pkg::t_rec              w_new_rec;
    fqkr_pkg::t_rec              w_hit_rec;
    logic                        w_exec;
    logic                        w_accept;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_exec     = (r_state == ST_EXEC);

    // Key and record from the held beat
    assign w_key             = r_op.ticket_id & fqkr_pkg::ID_MASK;
    assign w_new_rec.id      = w_key;
    assign w_new_rec.prio    = r_op.ticket_priority;
    assign w_new_rec.payload = r_op.ticket_payload;

    // First match from the head: lowest set bit
    assign w_first = w_match & (~w_match + DEPTH'(1));

    // Row of cells, each fed by the one behind it
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fqkr_pkg::t_rec w_next_rec;
        logic           w_next_valid;

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_rec   = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_rec   = w_rec[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        assign w_ctl[g].load  = w_exec && w_load[g];
        assign w_ctl[g].shift = w_exec && w_shift[g];

        fqkr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[g]),
            .i_new_rec    (w_new_rec),
            .i_next_rec   (w_next_rec),
            .i_next_valid (w_next_valid),
            .i_key        (w_key),
            .o_rec        (w_rec[g]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g])
        );
    end

    // Record of the selected cell, zero when none
    always_comb begin
        w_hit_rec = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_hit[i]) begin
                w_hit_rec = w_hit_rec | w_rec[i];
            end
        end
    end

    // Operation decode
    always_comb begin
        w_hit   = '0;
        w_shift = '0;
        w_load  = '0;
        n_count = r_count;
        n_out   = '0;
        unique case (fqkr_pkg::t_mode'(r_op.mode))
            fqkr_pkg::MODE_PUSH: begin
                n_out.out_id       = w_new_rec.id;
                n_out.out_priority = w_new_rec.prio;
                n_out.out_payload  = w_new_rec.payload;
                if (r_count >= CNT_W'(DEPTH)) begin
                    n_out.status = fqkr_pkg::STAT_FULL;
                end else begin
                    n_out.status = fqkr_pkg::STAT_OK;
                    w_load       = DEPTH'(1) << r_count;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            fqkr_pkg::MODE_POP: begin
                w_hit[0] = w_valid[0];
                w_shift  = w_valid[0] ? '1 : '0;
            end
            fqkr_pkg::MODE_REMOVE: begin
                w_hit   = w_first;
                w_shift = ~(w_first - DEPTH'(1));
            end
            fqkr_pkg::MODE_LOOKUP: begin
                w_hit = w_first;
            end
            default: begin
                w_hit = '0;
            end
        endcase
        if (r_op.mode != fqkr_pkg::MODE_PUSH) begin
            n_out.out_id       = w_hit_rec.id;
            n_out.out_priority = w_hit_rec.prio;
            n_out.out_payload  = w_hit_rec.payload;
            if (w_hit != '0) begin
                n_out.status = fqkr_pkg::STAT_OK;
                if (r_op.mode != fqkr_pkg::MODE_LOOKUP) begin
                    n_count = r_count - CNT_W'(1);
                end
            end else begin
                n_out.status = fqkr_pkg::STAT_MISS;
            end
        end
        n_out.occupancy = 5'(n_count);
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held beat and result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in_data;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("valid bits disagree with record count");

    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + DEPTH'(1))) == '0)
        else $error("valid cells not packed at the head");

    a_out_free_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !r_out_valid)
        else $error("result register busy when a result is written");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count beyond queue depth");

endmodule

// ===== rtl/core/fqkr_cell.sv =====
// fqkr_cell: one slot of the ticket queue: record, valid bit and key compare.
// Depends on fqkr_pkg.
module fqkr_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fqkr_pkg::t_cell_ctl i_ctl,
    input  fqkr_pkg::t_rec    i_new_rec,
    input  fqkr_pkg::t_rec    i_next_rec,
    input  logic              i_next_valid,
    input  logic [15:0]       i_key,
    output fqkr_pkg::t_rec    o_rec,
    output logic              o_valid,
    output logic              o_match
);

    fqkr_pkg::t_rec r_rec;
    logic           r_valid;

    // Valid bit: close up from the neighbour, or fill from a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end
    end

    // Record payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_rec <= i_next_rec;
        end else if (i_ctl.load) begin
            r_rec <= i_new_rec;
        end
    end

    assign o_rec   = r_rec;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_rec.id == i_key);

endmodule
